FILE: sv/drcc_pkg.sv
`timescale 1ns / 1ps

package drcc_pkg;

    // Defaults for the top-level parameters.
    localparam int PART_COUNT_DEF   = 8;
    localparam int LABEL_SECTOR_DEF = 0;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_READ_ONLY = 3'd1;
    localparam logic [2:0] ST_NOT_OPEN  = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_AT_END    = 3'd4;

    // Register indexes on the APB port (byte address is four times the index).
    localparam logic [2:0] REG_SECTOR_SIZE    = 3'd0;
    localparam logic [2:0] REG_SECTORS_TRACK  = 3'd1;
    localparam logic [2:0] REG_TRACKS_CYL     = 3'd2;
    localparam logic [2:0] REG_BLOCK_SHIFT    = 3'd3;
    localparam logic [2:0] REG_LABEL_WRITABLE = 3'd4;
    localparam logic [2:0] REG_LABELED_OPEN   = 3'd5;
    localparam logic [2:0] REG_OPEN_MASK      = 3'd6;

    // Register reset values.
    localparam logic [12:0] SECTOR_SIZE_RST = 13'd512;
    localparam logic [8:0]  SPT_RST         = 9'd32;
    localparam logic [8:0]  TPC_RST         = 9'd16;

    // One input transaction.
    typedef struct packed {
        logic               req_type;
        logic [2:0]         partition;
        logic               is_read;
        logic signed [31:0] block_number;
        logic [23:0]        byte_count;
        logic [31:0]        entry_offset;
        logic [31:0]        entry_size;
    } t_req;

    // One result transaction.
    typedef struct packed {
        logic [2:0]  status;
        logic        truncated;
        logic [23:0] granted_bytes;
        logic [31:0] cylinder;
        logic [7:0]  head;
        logic [7:0]  sector;
        logic        read_command;
    } t_rsp;

    // Request as decoded at the entry stage.
    typedef struct packed {
        logic               is_load;
        logic               ro;
        logic               nopen;
        logic               rd;
        logic [23:0]        bytes;
        logic [24:0]        szn;
        logic signed [38:0] sn;
        logic signed [39:0] absn;
        logic [31:0]        maxsz;
        logic [12:0]        ss;
        logic [8:0]         spt;
        logic [17:0]        spc;
    } t_ent;

    // Request plus its length in sectors.
    typedef struct packed {
        t_ent        ent;
        logic [24:0] sz;
    } t_mid;

    // Request plus length and cylinder.
    typedef struct packed {
        t_mid        mid;
        logic [31:0] cyl;
    } t_mid2;

endpackage

FILE: sv/disk_request_check_chs_map.sv
`timescale 1ns / 1ps

// Disk request checker and cylinder/head/sector mapper.
// Input channel (i_in_valid/o_in_ready/i_in_data) takes one transaction per cycle
// when ready: a partition table load or a transfer request. Each input transaction
// gives exactly one result transaction on o_out_valid/i_out_ready/o_out_data,
// in order. Table loads take effect at acceptance, so later requests see them.
// There are 79 register stages: one entry stage, a 25-stage divider for the
// sector count, a 33-stage divider for the cylinder, an 18-stage divider for
// head and sector, a decision stage and the output register holding the
// granted-byte multiply. One transaction enters per cycle unless the input stalls.
// Geometry and mode registers sit on the APB port; write them only while idle.
// A synchronous reset empties the pipeline, clears the partition table and
// loads the register defaults. When the receiver stalls, stages fill up one
// behind the other; the input keeps being accepted until the entry stage holds.
module disk_request_check_chs_map import drcc_pkg::*; #(
    parameter int PARTITION_COUNT = PART_COUNT_DEF,
    parameter int LABEL_SECTOR    = LABEL_SECTOR_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PIW = (PARTITION_COUNT > 1) ? $clog2(PARTITION_COUNT) : 1;
    localparam logic signed [41:0] LabelW = 42'(LABEL_SECTOR);

    // Configuration registers.
    logic [12:0] r_sector_size;
    logic [8:0]  r_spt;
    logic [8:0]  r_tpc;
    logic [2:0]  r_block_shift;
    logic        r_label_writable;
    logic        r_labeled_open;
    logic [7:0]  r_open_mask;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_size    <= SECTOR_SIZE_RST;
            r_spt            <= SPT_RST;
            r_tpc            <= TPC_RST;
            r_block_shift    <= '0;
            r_label_writable <= 1'b0;
            r_labeled_open   <= 1'b0;
            r_open_mask      <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SECTOR_SIZE:    r_sector_size    <= pwdata[12:0];
                REG_SECTORS_TRACK:  r_spt            <= pwdata[8:0];
                REG_TRACKS_CYL:     r_tpc            <= pwdata[8:0];
                REG_BLOCK_SHIFT:    r_block_shift    <= pwdata[2:0];
                REG_LABEL_WRITABLE: r_label_writable <= pwdata[0];
                REG_LABELED_OPEN:   r_labeled_open   <= pwdata[0];
                REG_OPEN_MASK:      r_open_mask      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            REG_SECTOR_SIZE:    prdata = {19'b0, r_sector_size};
            REG_SECTORS_TRACK:  prdata = {23'b0, r_spt};
            REG_TRACKS_CYL:     prdata = {23'b0, r_tpc};
            REG_BLOCK_SHIFT:    prdata = {29'b0, r_block_shift};
            REG_LABEL_WRITABLE: prdata = {31'b0, r_label_writable};
            REG_LABELED_OPEN:   prdata = {31'b0, r_labeled_open};
            REG_OPEN_MASK:      prdata = {24'b0, r_open_mask};
            default:            prdata = '0;
        endcase
    end

    // Handshake chain from the output back to the input.
    logic r_e_valid;
    logic r_d_valid;
    logic r_o_valid;
    logic hold_e;
    logic hold_d;
    logic hold_o;
    logic sz_in_ready;
    logic hs_out_valid;
    logic in_acc;

    assign hold_o     = r_o_valid & ~i_out_ready;
    assign hold_d     = r_d_valid & hold_o;
    assign hold_e     = r_e_valid & ~sz_in_ready;
    assign o_in_ready = ~hold_e;
    assign in_acc     = i_in_valid & o_in_ready;

    // Partition table.
    logic [31:0] r_off_tab  [PARTITION_COUNT];
    logic [31:0] r_size_tab [PARTITION_COUNT];
    logic [4:0]     pidx_w;
    logic           in_range;
    logic [PIW-1:0] pidx;

    assign pidx_w   = {2'b0, i_in_data.partition};
    assign in_range = (pidx_w < 5'(PARTITION_COUNT));
    assign pidx     = pidx_w[PIW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PARTITION_COUNT; i++) begin
                r_off_tab[i]  <= '0;
                r_size_tab[i] <= '0;
            end
        end else if (in_acc && i_in_data.req_type && in_range) begin
            r_off_tab[pidx]  <= i_in_data.entry_offset;
            r_size_tab[pidx] <= i_in_data.entry_size;
        end
    end

    // Entry stage: table lookup, early refusals, sector number and geometry.
    t_ent        ent_c;
    t_ent        r_ent;
    logic [31:0] off_c;
    logic [8:0]  spt_c;
    logic [8:0]  tpc_c;
    logic [17:0] spc_c;
    logic [38:0] blk_x;

    always_comb begin
        off_c = in_range ? r_off_tab[pidx] : '0;
        spt_c = (r_spt == '0) ? 9'd1 : r_spt;
        tpc_c = (r_tpc == '0) ? 9'd1 : r_tpc;
        spc_c = spt_c * tpc_c;
        blk_x = {{7{i_in_data.block_number[31]}}, i_in_data.block_number};

        ent_c.is_load = i_in_data.req_type;
        ent_c.ro      = ~r_labeled_open & ~i_in_data.is_read;
        ent_c.nopen   = ~in_range | ~r_open_mask[i_in_data.partition];
        ent_c.rd      = i_in_data.is_read;
        ent_c.bytes   = i_in_data.byte_count;
        ent_c.ss      = (r_sector_size == '0) ? 13'd1 : r_sector_size;
        ent_c.szn     = 25'(i_in_data.byte_count) + 25'(ent_c.ss) - 25'd1;
        ent_c.sn      = blk_x << r_block_shift;
        ent_c.absn    = {ent_c.sn[38], ent_c.sn} + {8'b0, off_c};
        ent_c.maxsz   = in_range ? r_size_tab[pidx] : '0;
        ent_c.spt     = spt_c;
        ent_c.spc     = spc_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (!hold_e) begin
            r_e_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold_e) begin
            r_ent <= ent_c;
        end
    end

    // Sector count: ceiling of bytes over sector size.
    logic        sz_v;
    logic        cy_in_ready;
    logic [24:0] sz_q;
    logic [12:0] sz_r;
    t_ent        sz_side;
    t_mid        cy_in_side;

    drcc_div #(.NW(25), .DW(13), .SW($bits(t_ent))) u_div_sz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e_valid),
        .o_ready (sz_in_ready),
        .i_num   (r_ent.szn),
        .i_den   (r_ent.ss),
        .i_side  (r_ent),
        .o_valid (sz_v),
        .i_ready (cy_in_ready),
        .o_quo   (sz_q),
        .o_rem   (sz_r),
        .o_side  (sz_side)
    );

    assign cy_in_side.ent = sz_side;
    assign cy_in_side.sz  = sz_q;

    // Cylinder: absolute sector over sectors per cylinder.
    logic        cy_v;
    logic        hs_in_ready;
    logic [32:0] cy_q;
    logic [17:0] cy_r;
    t_mid        cy_side;
    t_mid2       hs_in_side;

    drcc_div #(.NW(33), .DW(18), .SW($bits(t_mid))) u_div_cyl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sz_v),
        .o_ready (cy_in_ready),
        .i_num   (sz_side.absn[32:0]),
        .i_den   (sz_side.spc),
        .i_side  (cy_in_side),
        .o_valid (cy_v),
        .i_ready (hs_in_ready),
        .o_quo   (cy_q),
        .o_rem   (cy_r),
        .o_side  (cy_side)
    );

    assign hs_in_side.mid = cy_side;
    assign hs_in_side.cyl = cy_q[31:0];

    // Head and sector: remainder within the cylinder over sectors per track.
    logic [17:0] hs_q;
    logic [8:0]  hs_r;
    t_mid2       hs_side;

    drcc_div #(.NW(18), .DW(9), .SW($bits(t_mid2))) u_div_hs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cy_v),
        .o_ready (hs_in_ready),
        .i_num   (cy_r),
        .i_den   (cy_side.ent.spt),
        .i_side  (hs_in_side),
        .o_valid (hs_out_valid),
        .i_ready (~hold_d),
        .o_quo   (hs_q),
        .o_rem   (hs_r),
        .o_side  (hs_side)
    );

    // Decision stage: refusals, label protection, bounds, truncation.
    t_rsp               d_rsp;
    logic               d_trunc;
    logic [23:0]        d_szt;
    logic signed [41:0] sn_w;
    logic signed [41:0] absn_w;
    logic signed [41:0] sz_w;
    logic signed [41:0] max_w;
    logic signed [41:0] left_w;
    logic               lab_hit;
    t_rsp               r_d_rsp;
    logic               r_d_trunc;
    logic [23:0]        r_d_szt;
    logic [12:0]        r_d_ss;

    always_comb begin
        sn_w    = {{3{hs_side.mid.ent.sn[38]}}, hs_side.mid.ent.sn};
        absn_w  = {{2{hs_side.mid.ent.absn[39]}}, hs_side.mid.ent.absn};
        sz_w    = {17'b0, hs_side.mid.sz};
        max_w   = {10'b0, hs_side.mid.ent.maxsz};
        left_w  = max_w - sn_w;
        lab_hit = (absn_w <= LabelW) && ((LabelW == 42'sd0) || (absn_w + sz_w > LabelW))
                  && !hs_side.mid.ent.rd && !r_label_writable;
        d_rsp   = '0;
        d_trunc = 1'b0;
        d_szt   = left_w[23:0];

        if (hs_side.mid.ent.is_load) begin
            d_rsp = '0;
        end else if (hs_side.mid.ent.ro) begin
            d_rsp.status = ST_READ_ONLY;
        end else if (hs_side.mid.ent.nopen) begin
            d_rsp.status = ST_NOT_OPEN;
        end else if (lab_hit) begin
            d_rsp.status = ST_READ_ONLY;
        end else if (sn_w < 42'sd0) begin
            d_rsp.status = ST_INVALID;
        end else if ((sn_w + sz_w > max_w) && (sn_w == max_w)) begin
            d_rsp.status = ST_AT_END;
        end else if ((sn_w + sz_w > max_w) && (sn_w > max_w)) begin
            d_rsp.status = ST_INVALID;
        end else begin
            d_trunc              = (sn_w + sz_w > max_w);
            d_rsp.status         = ST_OK;
            d_rsp.truncated      = d_trunc;
            d_rsp.granted_bytes  = hs_side.mid.ent.bytes;
            d_rsp.cylinder       = hs_side.cyl;
            d_rsp.head           = hs_q[7:0];
            d_rsp.sector         = hs_r[7:0];
            d_rsp.read_command   = hs_side.mid.ent.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (!hold_d) begin
            r_d_valid <= hs_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold_d) begin
            r_d_rsp   <= d_rsp;
            r_d_trunc <= d_trunc;
            r_d_szt   <= d_szt;
            r_d_ss    <= hs_side.mid.ent.ss;
        end
    end

    // Output register: a truncated grant is the remaining sectors times sector size.
    logic [36:0] grant_prod;
    t_rsp        o_rsp_c;
    t_rsp        r_o_rsp;

    always_comb begin
        grant_prod = r_d_szt * r_d_ss;
        o_rsp_c    = r_d_rsp;
        if (r_d_trunc) begin
            o_rsp_c.granted_bytes = grant_prod[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (!hold_o) begin
            r_o_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold_o) begin
            r_o_rsp <= o_rsp_c;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_rsp;

    // A refusal or end of partition carries no transfer.
    a_refuse_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
            o_out_data.granted_bytes == '0 && !o_out_data.truncated &&
            o_out_data.cylinder == '0 && !o_out_data.read_command)
        else $error("refused result carries transfer fields");

    // Only an accepted request can be truncated.
    a_trunc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.truncated |-> o_out_data.status == ST_OK)
        else $error("truncation on a refused request");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ST_AT_END)
        else $error("undefined status code");

    // The input only stalls while the entry stage is occupied.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_e_valid)
        else $error("input stalled with empty entry stage");

endmodule

FILE: sv/drcc_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage, with a side payload
// carried alongside. Each stage holds only while it is full and the next one holds.
module drcc_div import drcc_pkg::*; #(
    parameter int NW = 24,
    parameter int DW = 13,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    logic [NW-1:0] r_v;
    logic [DW-1:0] r_rem  [NW];
    logic [NW-1:0] r_nq   [NW];
    logic [DW-1:0] r_den  [NW];
    logic [SW-1:0] r_side [NW];
    logic [NW-1:0] hold;

    // Last stage holds when the consumer stalls.
    assign hold[NW-1] = r_v[NW-1] & ~i_ready;

    genvar k;
    generate
        for (k = 0; k < NW; k++) begin : g_stage
            logic          s_v;
            logic [DW-1:0] s_rem;
            logic [NW-1:0] s_nq;
            logic [DW-1:0] s_den;
            logic [SW-1:0] s_side;
            logic [DW:0]   t;
            logic          ge;
            logic [DW:0]   diff;

            // Stage source: the input port or the previous stage.
            if (k == 0) begin : g_first
                assign s_v    = i_valid;
                assign s_rem  = '0;
                assign s_nq   = i_num;
                assign s_den  = i_den;
                assign s_side = i_side;
            end else begin : g_next
                assign s_v    = r_v[k-1];
                assign s_rem  = r_rem[k-1];
                assign s_nq   = r_nq[k-1];
                assign s_den  = r_den[k-1];
                assign s_side = r_side[k-1];
                assign hold[k-1] = r_v[k-1] & hold[k];
            end

            // One restoring step: bring in the next numerator bit, subtract if it fits.
            assign t    = {s_rem, s_nq[NW-1]};
            assign diff = t - {1'b0, s_den};
            assign ge   = (t >= {1'b0, s_den});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (!hold[k]) begin
                    r_v[k] <= s_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!hold[k]) begin
                    r_rem[k]  <= ge ? diff[DW-1:0] : t[DW-1:0];
                    r_nq[k]   <= {s_nq[NW-2:0], ge};
                    r_den[k]  <= s_den;
                    r_side[k] <= s_side;
                end
            end
        end
    endgenerate

    assign o_ready = ~hold[0];
    assign o_valid = r_v[NW-1];
    assign o_quo   = r_nq[NW-1];
    assign o_rem   = r_rem[NW-1];
    assign o_side  = r_side[NW-1];

endmodule
